// ----- design/wrc_pkg.sv -----
package wrc_pkg;

  localparam logic [23:0] SIGMA_Q48 = 24'd15960685;
  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [17:0] TEMP_MAX  = 18'd262143;
  localparam logic [22:0] COEFF_MAX = 23'd6553600;

  localparam int FRONT_STAGES = 13;
  localparam int DIV_BITS     = 18;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_BITS + 1;

  typedef enum logic [2:0] {
    REG_U_VALUE    = 3'd0,
    REG_G_VALUE    = 3'd1,
    REG_SOLAR_EXT  = 3'd2,
    REG_TEMP_EXT   = 3'd3,
    REG_TEMP_SKY   = 3'd4,
    REG_EMISSIVITY = 3'd5,
    REG_VIEW_SKY   = 3'd6
  } cfg_reg_t;

endpackage

// ----- design/wall_robin_coefficients.sv -----
// Wall face Robin coefficient unit.
// Input channel (in_valid/in_ready) carries one wall face per transfer:
// wall_temp, rad_flux, conductivity, delta_coeff. Output channel
// (out_valid/out_ready) returns value_fraction, ref_temp, total_coeff and
// zero_coeff for that face, in order, one result per face.
// The path from input transfer to out_valid runs through 13 stages of
// radiation coefficient and numerator arithmetic (the T^3 and sigma
// multiplies are split into partial products), 18 stages of a
// pipelined restoring divider that forms both quotients one bit a stage,
// and an output register. Throughput is one face per cycle unless stalled.
// Each stage advances whenever it is empty or the stage after it advances,
// so a stalled receiver holds only the stages that are full; in_ready stays
// high while any bubble remains in the pipeline.
// Configuration registers sit on the APB port at byte addresses 4*i; the
// user must write them only while the pipeline is empty; not enforced.
// Synchronous rst empties the pipeline and loads defaults; no clearing pass.
module wall_robin_coefficients (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [17:0]        wall_temp,
  input  logic signed [22:0] rad_flux,
  input  logic [27:0]        conductivity,
  input  logic [27:0]        delta_coeff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        value_fraction,
  output logic [17:0]        ref_temp,
  output logic [22:0]        total_coeff,
  output logic               zero_coeff
);

  localparam int NS = wrc_pkg::NUM_STAGES;
  localparam int FS = wrc_pkg::FRONT_STAGES;
  localparam int DB = wrc_pkg::DIV_BITS;

  // configuration
  logic [20:0] u_value;
  logic [16:0] g_value;
  logic [21:0] solar_ext;
  logic [17:0] temp_ext;
  logic [17:0] temp_sky;
  logic [16:0] emissivity;
  logic [16:0] view_sky;
  logic [16:0] vs, eps, gf;
  wrc_pkg::cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = wrc_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      u_value    <= 21'd15729;
      g_value    <= 17'd0;
      solar_ext  <= 22'd0;
      temp_ext   <= 18'd75008;
      temp_sky   <= 18'd72448;
      emissivity <= 17'd58982;
      view_sky   <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        wrc_pkg::REG_U_VALUE:    u_value    <= pwdata[20:0];
        wrc_pkg::REG_G_VALUE:    g_value    <= pwdata[16:0];
        wrc_pkg::REG_SOLAR_EXT:  solar_ext  <= pwdata[21:0];
        wrc_pkg::REG_TEMP_EXT:   temp_ext   <= pwdata[17:0];
        wrc_pkg::REG_TEMP_SKY:   temp_sky   <= pwdata[17:0];
        wrc_pkg::REG_EMISSIVITY: emissivity <= pwdata[16:0];
        wrc_pkg::REG_VIEW_SKY:   view_sky   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      wrc_pkg::REG_U_VALUE:    prdata = 32'(u_value);
      wrc_pkg::REG_G_VALUE:    prdata = 32'(g_value);
      wrc_pkg::REG_SOLAR_EXT:  prdata = 32'(solar_ext);
      wrc_pkg::REG_TEMP_EXT:   prdata = 32'(temp_ext);
      wrc_pkg::REG_TEMP_SKY:   prdata = 32'(temp_sky);
      wrc_pkg::REG_EMISSIVITY: prdata = 32'(emissivity);
      wrc_pkg::REG_VIEW_SKY:   prdata = 32'(view_sky);
      default:                 prdata = 32'd0;
    endcase
  end

  // fractions above one act as one
  assign vs  = (view_sky > wrc_pkg::FRAC_ONE) ? wrc_pkg::FRAC_ONE : view_sky;
  assign eps = (emissivity > wrc_pkg::FRAC_ONE) ? wrc_pkg::FRAC_ONE : emissivity;
  assign gf  = (g_value > wrc_pkg::FRAC_ONE) ? wrc_pkg::FRAC_ONE : g_value;

  // stage control
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // front stages
  logic [17:0]        s1_tw;
  logic signed [22:0] s1_q;
  logic [34:0]        s1_mix_a, s1_mix_b;
  logic [41:0]        s1_kd_lo, s1_kd_hi;

  logic [17:0]        s2_tw, s2_trad;
  logic signed [22:0] s2_q;
  logic [55:0]        s2_kd;

  logic [18:0]        s3_t;
  logic [17:0]        s3_trad;
  logic signed [22:0] s3_q;
  logic [55:0]        s3_kd;

  logic [37:0]        s4_t2;
  logic [18:0]        s4_t;
  logic [17:0]        s4_trad;
  logic signed [22:0] s4_q;
  logic [55:0]        s4_kd;

  logic [37:0]        s5_p_lo, s5_p_hi;
  logic [17:0]        s5_trad;
  logic signed [22:0] s5_q;
  logic [55:0]        s5_kd;

  logic [39:0]        s6_m;
  logic [17:0]        s6_trad;
  logic signed [22:0] s6_q;
  logic [55:0]        s6_kd;

  logic [43:0]        s7_n_lo, s7_n_hi;
  logic [17:0]        s7_trad;
  logic signed [22:0] s7_q;
  logic [55:0]        s7_kd;

  logic [39:0]        s8_n;
  logic [17:0]        s8_trad;
  logic signed [22:0] s8_q;
  logic [55:0]        s8_kd;

  logic [36:0]        s9_h_lo, s9_h_hi;
  logic [17:0]        s9_trad;
  logic signed [22:0] s9_q;
  logic [55:0]        s9_kd;

  logic [24:0]        s10_hrad;
  logic [17:0]        s10_trad;
  logic signed [22:0] s10_q;
  logic [55:0]        s10_kd;

  logic [25:0]        s11_heff;
  logic [42:0]        s11_hrtr;
  logic [38:0]        s11_ut, s11_gi;
  logic signed [22:0] s11_q;
  logic [55:0]        s11_kd;

  logic signed [45:0] s12_num;
  logic [56:0]        s12_sum;
  logic [25:0]        s12_heff;
  logic               s12_zero;
  logic [22:0]        s12_tc;

  logic [44:0]        s13_drt;
  logic [58:0]        s13_dvf;
  logic [25:0]        s13_heff;
  logic [56:0]        s13_sum;
  logic               s13_zero, s13_sat, s13_neg;
  logic [22:0]        s13_tc;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_tw    <= wall_temp;
      s1_q     <= rad_flux;
      s1_mix_a <= 35'(vs) * 35'(temp_sky);
      s1_mix_b <= 35'(17'(wrc_pkg::FRAC_ONE - vs)) * 35'(temp_ext);
      s1_kd_lo <= 42'(conductivity[13:0]) * 42'(delta_coeff);
      s1_kd_hi <= 42'(conductivity[27:14]) * 42'(delta_coeff);
    end
    if (en[1]) begin
      s2_tw   <= s1_tw;
      s2_q    <= s1_q;
      s2_trad <= 18'((36'(s1_mix_a) + 36'(s1_mix_b) + 36'd32768) >> 16);
      s2_kd   <= 56'(s1_kd_lo) + (56'(s1_kd_hi) << 14);
    end
    if (en[2]) begin
      s3_t    <= 19'(s2_tw) + 19'(s2_trad);
      s3_trad <= s2_trad;
      s3_q    <= s2_q;
      s3_kd   <= s2_kd;
    end
    if (en[3]) begin
      s4_t2   <= 38'(s3_t) * 38'(s3_t);
      s4_t    <= s3_t;
      s4_trad <= s3_trad;
      s4_q    <= s3_q;
      s4_kd   <= s3_kd;
    end
    if (en[4]) begin
      s5_p_lo <= 38'(s4_t2[18:0]) * 38'(s4_t);
      s5_p_hi <= 38'(s4_t2[37:19]) * 38'(s4_t);
      s5_trad <= s4_trad;
      s5_q    <= s4_q;
      s5_kd   <= s4_kd;
    end
    if (en[5]) begin
      s6_m    <= 40'((58'(s5_p_lo) + (58'(s5_p_hi) << 19) + 58'd65536) >> 17);
      s6_trad <= s5_trad;
      s6_q    <= s5_q;
      s6_kd   <= s5_kd;
    end
    if (en[6]) begin
      s7_n_lo <= 44'(s6_m[19:0]) * 44'(wrc_pkg::SIGMA_Q48);
      s7_n_hi <= 44'(s6_m[39:20]) * 44'(wrc_pkg::SIGMA_Q48);
      s7_trad <= s6_trad;
      s7_q    <= s6_q;
      s7_kd   <= s6_kd;
    end
    if (en[7]) begin
      s8_n    <= 40'((65'(s7_n_lo) + (65'(s7_n_hi) << 20) + 65'd8388608) >> 24);
      s8_trad <= s7_trad;
      s8_q    <= s7_q;
      s8_kd   <= s7_kd;
    end
    if (en[8]) begin
      s9_h_lo <= 37'(s8_n[19:0]) * 37'(eps);
      s9_h_hi <= 37'(s8_n[39:20]) * 37'(eps);
      s9_trad <= s8_trad;
      s9_q    <= s8_q;
      s9_kd   <= s8_kd;
    end
    if (en[9]) begin
      s10_hrad <= 25'((58'(s9_h_lo) + (58'(s9_h_hi) << 20) + 58'h80000000) >> 32);
      s10_trad <= s9_trad;
      s10_q    <= s9_q;
      s10_kd   <= s9_kd;
    end
    if (en[10]) begin
      s11_heff <= 26'(u_value) + 26'(s10_hrad);
      s11_hrtr <= 43'(s10_hrad) * 43'(s10_trad);
      s11_ut   <= 39'(u_value) * 39'(temp_ext);
      s11_gi   <= 39'(gf) * 39'(solar_ext);
      s11_q    <= s10_q;
      s11_kd   <= s10_kd;
    end
    if (en[11]) begin
      s12_num  <= $signed({7'd0, s11_ut}) + $signed({3'd0, s11_hrtr})
                + $signed({7'd0, s11_gi}) + ($signed(46'(s11_q)) <<< 16);
      s12_sum  <= (57'(s11_heff) << 16) + 57'(s11_kd);
      s12_heff <= s11_heff;
      s12_zero <= (s11_heff == 26'd0);
      s12_tc   <= (s11_heff > 26'(wrc_pkg::COEFF_MAX)) ? wrc_pkg::COEFF_MAX
                                                       : s11_heff[22:0];
    end
    if (en[12]) begin
      s13_drt  <= s12_num[44:0] + 45'(s12_heff >> 1);
      s13_sat  <= (s12_num[44:0] + 45'(s12_heff >> 1)) >= (45'(s12_heff) << DB);
      s13_neg  <= s12_num[45] || (s12_num == 46'sd0);
      s13_dvf  <= (59'(s12_heff) << 32) + 59'(s12_sum >> 1);
      s13_heff <= s12_heff;
      s13_sum  <= s12_sum;
      s13_zero <= s12_zero;
      s13_tc   <= s12_tc;
    end
  end

  // divider: one quotient bit of each division per stage, MSB first
  logic [44:0] dv_rrt [DB];
  logic [17:0] dv_qrt [DB];
  logic [58:0] dv_rvf [DB];
  logic [17:0] dv_qvf [DB];
  logic [25:0] dv_heff [DB];
  logic [56:0] dv_sum [DB];
  logic        dv_zero [DB];
  logic        dv_sat [DB];
  logic        dv_neg [DB];
  logic [22:0] dv_tc [DB];

  logic [44:0] dn_rrt [DB];
  logic [17:0] dn_qrt [DB];
  logic [58:0] dn_rvf [DB];
  logic [17:0] dn_qvf [DB];

  always_comb begin
    logic [44:0] r_rt;
    logic [17:0] q_rt;
    logic [58:0] r_vf;
    logic [17:0] q_vf;
    logic [25:0] h;
    logic [56:0] s;
    logic [44:0] trial_rt;
    logic [73:0] trial_vf;
    for (int j = 0; j < DB; j++) begin
      if (j == 0) begin
        r_rt = s13_drt;
        q_rt = '0;
        r_vf = s13_dvf;
        q_vf = '0;
        h    = s13_heff;
        s    = s13_sum;
      end else begin
        r_rt = dv_rrt[j-1];
        q_rt = dv_qrt[j-1];
        r_vf = dv_rvf[j-1];
        q_vf = dv_qvf[j-1];
        h    = dv_heff[j-1];
        s    = dv_sum[j-1];
      end
      trial_rt = 45'(h) << (DB - 1 - j);
      trial_vf = 74'(s) << (DB - 1 - j);
      dn_qrt[j] = q_rt;
      dn_qvf[j] = q_vf;
      if (r_rt >= trial_rt) begin
        dn_rrt[j] = r_rt - trial_rt;
        dn_qrt[j][DB-1-j] = 1'b1;
      end else begin
        dn_rrt[j] = r_rt;
      end
      if (74'(r_vf) >= trial_vf) begin
        dn_rvf[j] = 59'(74'(r_vf) - trial_vf);
        dn_qvf[j][DB-1-j] = 1'b1;
      end else begin
        dn_rvf[j] = r_vf;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DB; j++) begin
      if (en[FS+j]) begin
        dv_rrt[j] <= dn_rrt[j];
        dv_qrt[j] <= dn_qrt[j];
        dv_rvf[j] <= dn_rvf[j];
        dv_qvf[j] <= dn_qvf[j];
        if (j == 0) begin
          dv_heff[j] <= s13_heff;
          dv_sum[j]  <= s13_sum;
          dv_zero[j] <= s13_zero;
          dv_sat[j]  <= s13_sat;
          dv_neg[j]  <= s13_neg;
          dv_tc[j]   <= s13_tc;
        end else begin
          dv_heff[j] <= dv_heff[j-1];
          dv_sum[j]  <= dv_sum[j-1];
          dv_zero[j] <= dv_zero[j-1];
          dv_sat[j]  <= dv_sat[j-1];
          dv_neg[j]  <= dv_neg[j-1];
          dv_tc[j]   <= dv_tc[j-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      total_coeff <= dv_tc[DB-1];
      zero_coeff  <= dv_zero[DB-1];
      if (dv_zero[DB-1]) begin
        value_fraction <= 17'd0;
        ref_temp       <= temp_ext;
      end else begin
        value_fraction <= (dv_qvf[DB-1] > 18'(wrc_pkg::FRAC_ONE)) ? wrc_pkg::FRAC_ONE
                                                                  : dv_qvf[DB-1][16:0];
        if (dv_neg[DB-1]) begin
          ref_temp <= 18'd0;
        end else if (dv_sat[DB-1]) begin
          ref_temp <= wrc_pkg::TEMP_MAX;
        end else begin
          ref_temp <= dv_qrt[DB-1];
        end
      end
    end
  end

  a_zero_fraction: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_coeff |-> value_fraction == 17'd0 && total_coeff == 23'd0)
    else $error("zero coefficient with nonzero fraction or coefficient");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value_fraction <= wrc_pkg::FRAC_ONE)
    else $error("value fraction above one");

  a_coeff_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_coeff <= wrc_pkg::COEFF_MAX)
    else $error("total coefficient above saturation");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while receiver stalled");

endmodule

// ----- sim/wall_robin_coefficients_test.sv -----
module wall_robin_coefficients_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [4:0] UNMAPPED_ADDR = 5'd28;

  typedef struct {
    logic [16:0] value_fraction;
    logic [17:0] ref_temp;
    logic [22:0] total_coeff;
    logic        zero_coeff;
  } face_coeffs_t;

  class robin_scoreboard;
    logic [63:0] u_value, g_value, solar_ext, temp_ext, temp_sky, emissivity, view_sky;
    face_coeffs_t coeffs_due[$];
    int errors;

    function new();
      u_value = 64'd15729; g_value = 64'd0; solar_ext = 64'd0; temp_ext = 64'd75008;
      temp_sky = 64'd72448; emissivity = 64'd58982; view_sky = 64'd32768;
      errors = 0;
    endfunction

    function void set_reg(wrc_pkg::cfg_reg_t idx, logic [31:0] v);
      case (idx)
        wrc_pkg::REG_U_VALUE:    u_value = 64'(v[20:0]);
        wrc_pkg::REG_G_VALUE:    g_value = 64'(v[16:0]);
        wrc_pkg::REG_SOLAR_EXT:  solar_ext = 64'(v[21:0]);
        wrc_pkg::REG_TEMP_EXT:   temp_ext = 64'(v[17:0]);
        wrc_pkg::REG_TEMP_SKY:   temp_sky = 64'(v[17:0]);
        wrc_pkg::REG_EMISSIVITY: emissivity = 64'(v[16:0]);
        wrc_pkg::REG_VIEW_SKY:   view_sky = 64'(v[16:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] clamp_frac(logic [63:0] v);
      return (v > 64'd65536) ? 64'd65536 : v;
    endfunction

    function void note_face(logic [17:0] tw, logic signed [22:0] rf,
                            logic [27:0] k, logic [27:0] d);
      logic [63:0] vs, eps, g, trad, t, m, n, hrad, heff, h16, sum, vf, rt;
      longint num;
      face_coeffs_t r;
      vs = clamp_frac(view_sky);
      eps = clamp_frac(emissivity);
      g = clamp_frac(g_value);
      trad = (vs * temp_sky + (64'd65536 - vs) * temp_ext + 64'd32768) >> 16;
      t = 64'(tw) + trad;
      m = (t * t * t + (64'd1 << 16)) >> 17;
      n = (m * 64'd15960685 + (64'd1 << 23)) >> 24;
      hrad = (n * eps + (64'd1 << 31)) >> 32;
      heff = u_value + hrad;
      if (heff == 0) begin
        vf = 0;
        rt = temp_ext;
      end else begin
        h16 = heff << 16;
        sum = h16 + 64'(k) * 64'(d);
        vf = ((h16 << 16) + sum / 2) / sum;
        if (vf > 65536) vf = 65536;
        num = longint'(u_value * temp_ext) + longint'(hrad * trad)
            + longint'(g * solar_ext) + longint'(rf) * 65536;
        if (num <= 0) rt = 0;
        else begin
          rt = (64'(num) + heff / 2) / heff;
          if (rt > 262143) rt = 262143;
        end
      end
      r.value_fraction = vf[16:0];
      r.ref_temp = rt[17:0];
      r.total_coeff = (heff > 6553600) ? 23'd6553600 : heff[22:0];
      r.zero_coeff = (heff == 0);
      coeffs_due.push_back(r);
    endfunction

    function void check_result(face_coeffs_t got);
      face_coeffs_t want;
      if (coeffs_due.size() == 0) begin
        $error("result with no face outstanding");
        errors++;
        return;
      end
      want = coeffs_due.pop_front();
      if (got.value_fraction !== want.value_fraction) begin
        $error("value_fraction expected %0d actual %0d", want.value_fraction,
               got.value_fraction);
        errors++;
      end
      if (got.ref_temp !== want.ref_temp) begin
        $error("ref_temp expected %0d actual %0d", want.ref_temp, got.ref_temp);
        errors++;
      end
      if (got.total_coeff !== want.total_coeff) begin
        $error("total_coeff expected %0d actual %0d", want.total_coeff, got.total_coeff);
        errors++;
      end
      if (got.zero_coeff !== want.zero_coeff) begin
        $error("zero_coeff expected %0d actual %0d", want.zero_coeff, got.zero_coeff);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst, psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready, zero_coeff;
  logic [17:0] wall_temp, ref_temp;
  logic signed [22:0] rad_flux;
  logic [27:0] conductivity, delta_coeff;
  logic [16:0] value_fraction;
  logic [22:0] total_coeff;

  robin_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  wall_robin_coefficients dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    face_coeffs_t got;
    if (!rst && in_valid && in_ready) sb.note_face(wall_temp, rad_flux, conductivity,
                                                   delta_coeff);
    if (!rst && out_valid && out_ready) begin
      got.value_fraction = value_fraction;
      got.ref_temp = ref_temp;
      got.total_coeff = total_coeff;
      got.zero_coeff = zero_coeff;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("wall_robin_coefficients_test failed");
      $finish;
    end
  end

  task automatic apb_write(logic [4:0] addr, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic write_reg(wrc_pkg::cfg_reg_t idx, logic [31:0] v);
    apb_write({idx, 2'b00}, v);
    sb.set_reg(idx, v);
  endtask

  task automatic send_face(logic [17:0] tw, logic signed [22:0] rf,
                           logic [27:0] k, logic [27:0] d);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (gap > 0) repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    wall_temp <= tw; rad_flux <= rf; conductivity <= k; delta_coeff <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random_face();
    logic [17:0] tw;
    logic signed [22:0] rf;
    logic [27:0] k, d;
    if ($urandom_range(3) == 0) begin
      tw = 18'($urandom); rf = 23'($urandom); k = 28'($urandom); d = 28'($urandom);
    end else begin
      tw = 18'($urandom_range(90000, 50000));
      rf = 23'($signed($urandom_range(5242880)) - 32'sd2621440);
      k = 28'($urandom_range(1048576));
      d = 28'($urandom_range(2560000));
    end
    send_face(tw, rf, k, d);
  endtask

  task automatic wait_drained();
    // drop valid first so the last transfer is not taken again
    in_valid <= 1'b0;
    while (sb.coeffs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(int which);
    case (which)
      1: begin // all registers at zero: no coefficient at all
        write_reg(wrc_pkg::REG_U_VALUE, 0); write_reg(wrc_pkg::REG_G_VALUE, 0);
        write_reg(wrc_pkg::REG_SOLAR_EXT, 0); write_reg(wrc_pkg::REG_TEMP_EXT, 0);
        write_reg(wrc_pkg::REG_TEMP_SKY, 0); write_reg(wrc_pkg::REG_EMISSIVITY, 0);
        write_reg(wrc_pkg::REG_VIEW_SKY, 0);
      end
      2: begin // all bits set: fractions beyond one, hottest temperatures
        write_reg(wrc_pkg::REG_U_VALUE, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_G_VALUE, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_SOLAR_EXT, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_TEMP_EXT, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_TEMP_SKY, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_EMISSIVITY, 32'hFFFF_FFFF);
        write_reg(wrc_pkg::REG_VIEW_SKY, 32'hFFFF_FFFF);
      end
      default: begin
        write_reg(wrc_pkg::REG_U_VALUE, $urandom_range(1310720));
        write_reg(wrc_pkg::REG_G_VALUE, $urandom_range(65536));
        write_reg(wrc_pkg::REG_SOLAR_EXT, $urandom_range(2621440));
        write_reg(wrc_pkg::REG_TEMP_EXT, $urandom_range(80000, 60000));
        write_reg(wrc_pkg::REG_TEMP_SKY, $urandom_range(78000, 50000));
        write_reg(wrc_pkg::REG_EMISSIVITY, $urandom_range(65536));
        write_reg(wrc_pkg::REG_VIEW_SKY, $urandom_range(65536));
      end
    endcase
  endtask

  initial begin
    rst = 1'b1; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; wall_temp = '0; rad_flux = '0; conductivity = '0;
    delta_coeff = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: field extremes, hot and negative references
    send_face(18'd0, 23'sd0, 28'd0, 28'd0);
    send_face(18'h3FFFF, 23'sd0, 28'd0, 28'd0);
    send_face(18'd75000, -23'sd4194304, 28'd436207, 28'd25600);
    send_face(18'd75000, 23'sd4194303, 28'd436207, 28'd25600);
    send_face(18'd75000, 23'sd2621440, 28'hFFFFFFF, 28'hFFFFFFF);
    send_face(18'h3FFFF, -23'sd2621440, 28'hFFFFFFF, 28'd1);
    send_face(18'd1, 23'sd1, 28'd1, 28'hFFFFFFF);
    send_face(18'd70000, 23'sd0, 28'd436207, 28'd256);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        load_setting(phase == 7 ? 2 : phase);
        if (phase == 4) apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      end
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (phase == 1 || phase == 2 || phase == 7) begin
        send_face(18'h3FFFF, 23'sd0, 28'd0, 28'd0);
        send_face(18'd0, -23'sd4194304, 28'hFFFFFFF, 28'hFFFFFFF);
        send_face(18'h3FFFF, 23'sd4194303, 28'd1, 28'd1);
      end
      if (phase == 3) hold_cycles = 300;
      repeat (135) send_random_face();
      wait_drained();
    end

    if (sb.errors == 0) $display("wall_robin_coefficients_test passed");
    else $display("wall_robin_coefficients_test failed");
    $finish;
  end
endmodule
